// File: rtl/core/assert_macros.svh
// assertion helpers for the core rtl
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bpro_pkg.sv
// shared widths, pipeline stage records and result record for the range/owner unit
// no dependencies
package bpro_pkg;

   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned PART_W     = 16;
   localparam int unsigned SPAN_W     = TOTAL_W + 1;
   localparam int unsigned QUOT_STEPS = TOTAL_W;
   localparam int unsigned OWN_STEPS  = PART_W;
   localparam int unsigned TRIAL_W    = SPAN_W + OWN_STEPS - 1;
   localparam int unsigned SKID_DEPTH = 2;
   localparam int unsigned SKID_PTR_W = $clog2(SKID_DEPTH);
   localparam int unsigned SKID_CNT_W = $clog2(SKID_DEPTH + 1);

   typedef logic [TOTAL_W-1:0] count_type;
   typedef logic [PART_W-1:0]  part_type;
   typedef logic [SPAN_W-1:0]  span_type;

   // total / parts, one quotient bit per stage
   typedef struct packed {
      part_type  rem;
      count_type tq;
      part_type  part;
      count_type index;
      part_type  parts;
      logic      index_error;
      logic      part_error;
   } div_stage_type;

   // products and range addends
   typedef struct packed {
      count_type prod;
      count_type big_span;
      count_type add_start;
      count_type add_end;
      count_type index;
      part_type  rem;
      count_type q;
      span_type  q1;
      logic      index_error;
      logic      part_error;
   } mul_stage_type;

   // owner division, one quotient bit per stage
   typedef struct packed {
      count_type range_start;
      count_type range_end;
      part_type  rem;
      logic      below_span;
      logic      index_error;
      logic      part_error;
      count_type num;
      span_type  den;
      part_type  quot;
   } own_stage_type;

   typedef struct packed {
      count_type range_start;
      count_type range_end;
      part_type  owner;
      logic      index_error;
      logic      part_error;
   } rsp_type;

endpackage

// File: rtl/core/bpro_pipe.sv
// datapath pipeline: total/parts divider, multiply stage, owner divider
// depends on bpro_pkg
module bpro_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  bpro_pkg::count_type in_total_items,
   input  bpro_pkg::part_type  in_part,
   input  bpro_pkg::count_type in_index,
   input  bpro_pkg::part_type  in_parts,
   output logic                out_valid,
   output bpro_pkg::rsp_type   out_rsp
);
   import bpro_pkg::*;

   // restoring step on the remainder, dividend bits shift out as quotient bits shift in
   function automatic div_stage_type div_step(input div_stage_type cur);
      logic [PART_W:0] shifted;
      logic            fits;
      div_stage_type   nxt;
      shifted = {cur.rem, cur.tq[TOTAL_W-1]};
      fits    = shifted >= {1'b0, cur.parts};
      nxt     = cur;
      nxt.rem = fits ? PART_W'(shifted - {1'b0, cur.parts}) : shifted[PART_W-1:0];
      nxt.tq  = {cur.tq[TOTAL_W-2:0], fits};
      return nxt;
   endfunction

   // compare against the divisor shifted to the current quotient bit
   function automatic own_stage_type own_step(input own_stage_type cur,
                                              input int unsigned   shift);
      logic [TRIAL_W-1:0] trial;
      logic               fits;
      own_stage_type      nxt;
      trial    = TRIAL_W'(cur.den) << shift;
      fits     = TRIAL_W'(cur.num) >= trial;
      nxt      = cur;
      nxt.num  = fits ? cur.num - trial[TOTAL_W-1:0] : cur.num;
      nxt.quot = {cur.quot[PART_W-2:0], fits};
      return nxt;
   endfunction

   logic          div_vld_ff [0:QUOT_STEPS];
   div_stage_type div_ff     [0:QUOT_STEPS];
   div_stage_type div_in     [0:QUOT_STEPS];

   logic          mul_vld_ff;
   mul_stage_type mul_ff;
   mul_stage_type mul_in;

   logic          own_vld_ff [0:OWN_STEPS];
   own_stage_type own_ff     [0:OWN_STEPS];
   own_stage_type own_in     [0:OWN_STEPS];

   div_stage_type                  div_last;
   span_type                       q1;
   logic                           part_low;
   count_type                      factor;
   logic [TOTAL_W+PART_W-1:0]      prod_full;
   logic [SPAN_W+PART_W-1:0]       span_full;
   own_stage_type                  own_last;

   // entry and divider steps
   always_comb begin
      div_in[0].rem         = '0;
      div_in[0].tq          = in_total_items;
      div_in[0].part        = in_part;
      div_in[0].index       = in_index;
      div_in[0].parts       = in_parts;
      div_in[0].index_error = in_index >= in_total_items;
      div_in[0].part_error  = in_part >= in_parts;
      for (int k = 0; k < QUOT_STEPS; k++) begin
         div_in[k+1] = div_step(div_ff[k]);
      end
   end

   // multiply stage: part * block size and r * (q + 1)
   always_comb begin
      div_last  = div_ff[QUOT_STEPS];
      q1        = SPAN_W'(div_last.tq) + SPAN_W'(1);
      part_low  = div_last.part < div_last.rem;
      factor    = part_low ? q1[TOTAL_W-1:0] : div_last.tq;
      prod_full = div_last.part * factor;
      span_full = div_last.rem * q1;

      mul_in.prod        = prod_full[TOTAL_W-1:0];
      mul_in.big_span    = span_full[TOTAL_W-1:0];
      mul_in.add_start   = part_low ? '0 : TOTAL_W'(div_last.rem);
      mul_in.add_end     = part_low ? q1[TOTAL_W-1:0]
                                    : TOTAL_W'(div_last.rem) + div_last.tq;
      mul_in.index       = div_last.index;
      mul_in.rem         = div_last.rem;
      mul_in.q           = div_last.tq;
      mul_in.q1          = q1;
      mul_in.index_error = div_last.index_error;
      mul_in.part_error  = div_last.part_error;
   end

   // range sums, owner divider setup and steps
   always_comb begin
      own_in[0].range_start = mul_ff.prod + mul_ff.add_start;
      own_in[0].range_end   = mul_ff.prod + mul_ff.add_end;
      own_in[0].rem         = mul_ff.rem;
      own_in[0].below_span  = mul_ff.index < mul_ff.big_span;
      own_in[0].index_error = mul_ff.index_error;
      own_in[0].part_error  = mul_ff.part_error;
      own_in[0].num         = own_in[0].below_span ? mul_ff.index
                                                   : mul_ff.index - mul_ff.big_span;
      own_in[0].den         = own_in[0].below_span ? mul_ff.q1 : SPAN_W'(mul_ff.q);
      own_in[0].quot        = '0;
      for (int k = 0; k < OWN_STEPS; k++) begin
         own_in[k+1] = own_step(own_ff[k], OWN_STEPS - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUOT_STEPS; k++) div_vld_ff[k] <= 1'b0;
         mul_vld_ff <= 1'b0;
         for (int k = 0; k <= OWN_STEPS; k++) own_vld_ff[k] <= 1'b0;
      end else if (advance) begin
         div_vld_ff[0] <= in_valid;
         for (int k = 1; k <= QUOT_STEPS; k++) div_vld_ff[k] <= div_vld_ff[k-1];
         mul_vld_ff    <= div_vld_ff[QUOT_STEPS];
         own_vld_ff[0] <= mul_vld_ff;
         for (int k = 1; k <= OWN_STEPS; k++) own_vld_ff[k] <= own_vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= QUOT_STEPS; k++) div_ff[k] <= div_in[k];
         mul_ff <= mul_in;
         for (int k = 0; k <= OWN_STEPS; k++) own_ff[k] <= own_in[k];
      end
   end

   // owner: index / (q+1) below the big span, else r + offset / q
   always_comb begin
      own_last                = own_ff[OWN_STEPS];
      out_valid               = own_vld_ff[OWN_STEPS];
      out_rsp.range_start     = own_last.range_start;
      out_rsp.range_end       = own_last.range_end;
      out_rsp.index_error     = own_last.index_error;
      out_rsp.part_error      = own_last.part_error;
      if (own_last.index_error) begin
         out_rsp.owner = '0;
      end else if (own_last.below_span) begin
         out_rsp.owner = own_last.quot;
      end else begin
         out_rsp.owner = own_last.rem + own_last.quot;
      end
   end

endmodule

// File: rtl/core/block_partition_range_owner_unit.sv
// block_partition_range_owner_unit: block distribution range and owner lookup
// depends on bpro_pkg, bpro_pipe and assert_macros.svh
// For a request of (total_items, part, index) the unit returns the half-open range
// [range_start, range_end) that part owns when total_items items are split into
// num_parts consecutive blocks with the first total mod num_parts blocks one item
// larger, and the part that owns index. A part count of zero acts as one.
// index_error flags index >= total_items (owner then reads 0); part_error flags
// part >= num_parts (the range is still formed and wraps at 32 bits). The unit
// takes one request per clock while the output buffer has room, and holds nothing
// between requests. A request passes a 33-stage total/parts divider retiring one
// quotient bit per stage, a multiply stage, a 17-stage owner divider retiring one
// owner bit per stage, and a two-entry output buffer. The whole pipeline advances
// together whenever the output buffer has room, so a request is still taken while
// one response waits; num_parts is sampled when a request enters and must only be
// written while the unit is drained.
`include "assert_macros.svh"

module block_partition_range_owner_unit (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  bpro_pkg::count_type req_total_items,
   input  bpro_pkg::part_type  req_part,
   input  bpro_pkg::count_type req_index,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bpro_pkg::count_type rsp_range_start,
   output bpro_pkg::count_type rsp_range_end,
   output bpro_pkg::part_type  rsp_owner,
   output logic                rsp_index_error,
   output logic                rsp_part_error,

   input  logic                csr_wr_en,
   input  bpro_pkg::part_type  csr_wr_data
);
   import bpro_pkg::*;

   // part count register, zero treated as one
   part_type parts_ff;
   part_type parts_eff;

   // pipeline hookup
   logic     advance;
   logic     pipe_valid;
   rsp_type  pipe_rsp;

   // two-entry output buffer
   rsp_type                 skid_ff [0:SKID_DEPTH-1];
   logic [SKID_PTR_W-1:0]   wr_ptr_ff;
   logic [SKID_PTR_W-1:0]   wr_ptr_in;
   logic [SKID_PTR_W-1:0]   rd_ptr_ff;
   logic [SKID_PTR_W-1:0]   rd_ptr_in;
   logic [SKID_CNT_W-1:0]   skid_cnt_ff;
   logic [SKID_CNT_W-1:0]   skid_cnt_in;
   logic                    push;
   logic                    pop;
   rsp_type                 head;

   always_ff @(posedge clock) begin
      if (reset) begin
         parts_ff <= PART_W'(1);
      end else if (csr_wr_en) begin
         parts_ff <= csr_wr_data;
      end
   end

   assign parts_eff = (parts_ff == '0) ? PART_W'(1) : parts_ff;

   // the pipeline moves as one whenever the buffer is not full
   assign advance   = skid_cnt_ff != SKID_CNT_W'(SKID_DEPTH);
   assign req_ready = advance;

   bpro_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (req_valid),
      .in_total_items (req_total_items),
      .in_part        (req_part),
      .in_index       (req_index),
      .in_parts       (parts_eff),
      .out_valid      (pipe_valid),
      .out_rsp        (pipe_rsp)
   );

   // result leaves the last stage into the buffer on each advance
   assign push = advance && pipe_valid;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      skid_cnt_in = skid_cnt_ff + SKID_CNT_W'(push) - SKID_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         skid_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         skid_cnt_ff <= skid_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         skid_ff[wr_ptr_ff] <= pipe_rsp;
      end
   end

   // oldest buffered response drives the port
   assign head            = skid_ff[rd_ptr_ff];
   assign rsp_valid       = skid_cnt_ff != '0;
   assign rsp_range_start = head.range_start;
   assign rsp_range_end   = head.range_end;
   assign rsp_owner       = head.owner;
   assign rsp_index_error = head.index_error;
   assign rsp_part_error  = head.part_error;

   // buffer occupancy never passes its depth
   `ASSERT_ALWAYS(a_skid_bound, skid_cnt_ff <= SKID_CNT_W'(SKID_DEPTH), "output buffer overflow")
   // an out-of-range index always reports owner zero
   `ASSERT_IMPLIES(a_owner_on_error, rsp_valid && rsp_index_error, rsp_owner == '0, "owner set on index error")
   // a part in range owns a range that does not wrap
   `ASSERT_IMPLIES(a_range_order, rsp_valid && !rsp_part_error, rsp_range_start <= rsp_range_end, "range reversed for valid part")

endmodule

// File: tb/sv/tb_top.sv
// self-checking bench for block_partition_range_owner_unit: range and owner lookup
// depends on bpro_pkg and the unit rtl; a small ledger class predicts and checks responses
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpro_pkg::*;

   localparam int unsigned HALF_PERIOD   = 5;
   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned DRAIN_CYCLES  = 60;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_ITEMS   = 146;
   localparam int unsigned MAX_GAP       = 11;

   // ledger: shadow part count, predicted responses in arrival order, error tally
   class range_owner_ledger;
      part_type part_count;
      rsp_type  awaited_lookups[$];
      int unsigned mismatches;
      int unsigned responses;
      int unsigned index_errors;
      int unsigned part_errors;

      function new();
         part_count = 16'd1;
      endfunction

      function void set_part_count(part_type value);
         part_count = value;
      endfunction

      function int unsigned pending();
         return awaited_lookups.size();
      endfunction

      // block split of total over the part count, range of part, holder of index
      function rsp_type lookup_range_owner(count_type total, part_type part,
                                           count_type index);
         logic [63:0] parts, base_len, extra, first, past, long_span, holder;
         rsp_type r;
         parts    = (part_count == 16'd0) ? 64'd1 : 64'(part_count);
         base_len = 64'(total) / parts;
         extra    = 64'(total) % parts;
         if (64'(part) < extra) begin
            first = 64'(part) * (base_len + 64'd1);
            past  = first + base_len + 64'd1;
         end else begin
            first = 64'(part) * base_len + extra;
            past  = first + base_len;
         end
         holder = 64'd0;
         if (index < total) begin
            long_span = extra * (base_len + 64'd1);
            if (64'(index) < long_span) begin
               holder = 64'(index) / (base_len + 64'd1);
            end else if (base_len != 64'd0) begin
               holder = extra + (64'(index) - long_span) / base_len;
            end
         end
         r.range_start = first[31:0];
         r.range_end   = past[31:0];
         r.owner       = holder[15:0];
         r.index_error = (index >= total);
         r.part_error  = (64'(part) >= parts);
         return r;
      endfunction

      function void note_request(count_type total, part_type part, count_type index);
         awaited_lookups.insert(awaited_lookups.size(),
                                lookup_range_owner(total, part, index));
      endfunction

      task report_mismatch(string line);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, line);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited_lookups.size() == 0) begin
            report_mismatch($sformatf("response with no request pending, start %0h",
                                      got.range_start));
         end else begin
            want = awaited_lookups.pop_front();
            responses++;
            if (got.index_error) index_errors++;
            if (got.part_error) part_errors++;
            if (got.range_start !== want.range_start)
               report_mismatch($sformatf("range_start got %0h want %0h",
                                         got.range_start, want.range_start));
            if (got.range_end !== want.range_end)
               report_mismatch($sformatf("range_end got %0h want %0h",
                                         got.range_end, want.range_end));
            if (got.owner !== want.owner)
               report_mismatch($sformatf("owner got %0h want %0h",
                                         got.owner, want.owner));
            if (got.index_error !== want.index_error)
               report_mismatch($sformatf("index_error got %0b want %0b",
                                         got.index_error, want.index_error));
            if (got.part_error !== want.part_error)
               report_mismatch($sformatf("part_error got %0b want %0b",
                                         got.part_error, want.part_error));
         end
      endtask
   endclass

   // clock, reset and every unit input start at known values
   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   count_type req_total_items = '0;
   part_type  req_part = '0;
   count_type req_index = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   count_type rsp_range_start;
   count_type rsp_range_end;
   part_type  rsp_owner;
   logic      rsp_index_error;
   logic      rsp_part_error;
   logic      csr_wr_en = 1'b0;
   part_type  csr_wr_data = '0;

   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   // when set, that side runs back to back with no idle cycles
   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;

   range_owner_ledger ledger = new();

   block_partition_range_owner_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_total_items (req_total_items),
      .req_part        (req_part),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_owner       (rsp_owner),
      .rsp_index_error (rsp_index_error),
      .rsp_part_error  (rsp_part_error),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog: a hung handshake or a lost response ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[block_partition_range_owner_unit] ERROR");
         $finish;
      end
   end

   function automatic int unsigned draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // one request: optional idle gap, then hold valid and payload until taken
   // called at a rising edge, returns at the edge that accepted the request
   task automatic send_request(count_type total, part_type part, count_type index);
      int unsigned gap;
      gap = draw_gap(send_steady);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_total_items <= total;
      req_part        <= part;
      req_index       <= index;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(total, part, index);
      requests_sent++;
   endtask

   // stop sending and wait for every predicted response to come back
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // part count write, only ever issued with the unit drained
   task automatic write_part_count(part_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.set_part_count(value);
      settings_used++;
   endtask

   // part count for each random phase: one, full scale, zero, small, mid, any
   function automatic part_type pick_part_count(int unsigned phase);
      case (phase % 6)
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return 16'd0;
         3: return part_type'($urandom_range(2, 16));
         4: return part_type'($urandom_range(17, 4096));
         default: return part_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly well-formed lookups (part in range, index inside the total),
   // with boundary indexes and a share of out-of-range parts and indexes
   function automatic void pick_request(output count_type total, output part_type part,
                                        output count_type index);
      int unsigned parts;
      rsp_type probe;
      parts = (ledger.part_count == 16'd0) ? 1 : ledger.part_count;
      case ($urandom_range(0, 5))
         0: total = $urandom_range(0, 3 * parts);
         1: total = $urandom_range(0, 200);
         2: total = 32'hFFFF_FFFF - $urandom_range(0, 200);
         3: total = parts * $urandom_range(1, 5000) + $urandom_range(0, 2) - 1;
         default: total = $urandom();
      endcase
      if ($urandom_range(0, 4) != 0) begin
         part = part_type'($urandom_range(0, parts - 1));
      end else begin
         case ($urandom_range(0, 2))
            0: part = part_type'(parts);
            1: part = 16'hFFFF;
            default: part = part_type'($urandom_range(0, 65535));
         endcase
      end
      if (total != 0 && $urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 4))
            0: index = total - 1;
            1: index = 32'd0;
            2: begin
               // straddle the first index that part owns
               probe = ledger.lookup_range_owner(total, part, 32'd0);
               index = probe.range_start - $urandom_range(0, 1);
            end
            default: index = $urandom_range(0, total - 1);
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: index = total;
            1: index = 32'hFFFF_FFFF;
            default: index = $urandom();
         endcase
      end
   endfunction

   // request side: directed corners first, then random phases
   initial begin : request_side
      count_type total;
      count_type index;
      part_type  part;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // part count still at its reset value of one
      send_request(32'd0, 16'd0, 32'd0);
      send_request(32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFE);
      send_request(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(32'd10, 16'd1, 32'd9);
      // sender holds off until every response is back
      drain();

      // seven parts over 23 items: two long blocks then short ones
      write_part_count(16'd7);
      send_request(32'd23, 16'd0, 32'd0);
      send_request(32'd23, 16'd1, 32'd7);
      send_request(32'd23, 16'd2, 32'd8);
      send_request(32'd23, 16'd6, 32'd22);
      send_request(32'd23, 16'd7, 32'd23);
      send_request(32'd23, 16'hFFFF, 32'hFFFF_FFFF);
      // fewer items than parts, so the short blocks are empty
      send_request(32'd3, 16'd2, 32'd2);
      send_request(32'd3, 16'd5, 32'd1);
      send_request(32'd0, 16'd3, 32'd0);
      drain();

      // full-scale part count, ranges that wrap past 32 bits
      write_part_count(16'hFFFF);
      send_request(32'hFFFF_FFFF, 16'hFFFE, 32'hFFFF_FFFE);
      send_request(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
      send_request(32'd65534, 16'd65534, 32'd65533);
      send_request(32'd65536, 16'd0, 32'd65535);
      send_request(32'd1, 16'd0, 32'd0);
      drain();

      // zero part count behaves as one
      write_part_count(16'd0);
      send_request(32'd5, 16'd0, 32'd4);
      send_request(32'd5, 16'd1, 32'd0);

      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         write_part_count(pick_part_count(phase));
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            pick_request(total, part, index);
            send_request(total, part, index);
         end
      end

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over %0d part-count settings incl. zero and full scale",
               requests_sent, settings_used);
      $display("checked %0d responses: %0d with index error, %0d with part error",
               ledger.responses, ledger.index_errors, ledger.part_errors);
      if (ledger.mismatches == 0) begin
         $display("[block_partition_range_owner_unit] OK");
      end else begin
         $display("[block_partition_range_owner_unit] ERROR");
      end
      $finish;
   end

   // response side: random stalls on rsp_ready, every accepted response checked
   initial begin : response_side
      int unsigned stall;
      rsp_type got;
      wait (reset == 1'b0);
      forever begin
         stall = draw_gap(recv_steady);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.range_start = rsp_range_start;
         got.range_end   = rsp_range_end;
         got.owner       = rsp_owner;
         got.index_error = rsp_index_error;
         got.part_error  = rsp_part_error;
         ledger.check_response(got);
      end
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bpro_pkg.sv
rtl/core/bpro_pipe.sv
rtl/core/block_partition_range_owner_unit.sv
tb/sv/tb_top.sv
